@@ hw/rtl/ict_pkg.sv @@
// Shared types, codes and tables for the interrupt controller with timer.
package ict_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_IRQ_MASK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_ON  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_RATE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELOAD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LCD_ON    = 3'd4;

    localparam logic [1:0] FUNC_TICK     = 2'd0;
    localparam logic [1:0] FUNC_RAISE    = 2'd1;
    localparam logic [1:0] FUNC_BOUNDARY = 2'd2;

    localparam int NUM_SRC = 5;

    localparam logic [2:0] SRC_VBLANK = 3'd0;
    localparam logic [2:0] SRC_LCD    = 3'd1;
    localparam logic [2:0] SRC_TIMER  = 3'd2;
    localparam logic [2:0] SRC_SERIAL = 3'd3;
    localparam logic [2:0] SRC_PAD    = 3'd4;

    typedef struct packed {
        logic       ovf;
        logic [7:0] counter;
    } t_tmr_stat;

    typedef struct packed {
        logic                 taken;
        logic [6:0]           vector;
        logic [15:0]          push_addr;
        logic [15:0]          push_value;
        logic [15:0]          new_sp;
        logic [NUM_SRC-1:0]   pending;
        logic                 attention;
    } t_irq_res;

    function automatic logic [10:0] period_of(input logic [1:0] rate);
        logic [10:0] per;
        case (rate)
            2'd0:    per = 11'd1024;
            2'd1:    per = 11'd16;
            2'd2:    per = 11'd64;
            default: per = 11'd256;
        endcase
        return per;
    endfunction

    function automatic logic [6:0] vector_of(input logic [2:0] src);
        logic [6:0] vec;
        case (src)
            SRC_VBLANK: vec = 7'h40;
            SRC_LCD:    vec = 7'h48;
            SRC_TIMER:  vec = 7'h50;
            SRC_SERIAL: vec = 7'h58;
            SRC_PAD:    vec = 7'h60;
            default:    vec = 7'h00;
        endcase
        return vec;
    endfunction

endpackage

@@ hw/rtl/ict_timer.sv @@
// Timer prescaler and 8-bit counter with reload on overflow.
module ict_timer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [5:0]          i_cycles,
    input  logic [1:0]          i_rate,
    input  logic [7:0]          i_reload,
    output ict_pkg::t_tmr_stat  o_stat
);

    logic [10:0] r_presc;
    logic [10:0] n_presc;
    logic [7:0]  r_counter;
    logic [7:0]  n_counter;
    logic [11:0] w_sum;
    logic [10:0] w_acc;
    logic [10:0] w_per;
    logic [7:0]  w_inc;
    logic        w_ovf;

    always_comb begin
        w_sum     = {1'b0, r_presc} + {6'd0, i_cycles};
        w_acc     = w_sum[10:0];
        w_per     = ict_pkg::period_of(i_rate);
        w_inc     = r_counter + 8'd1;
        n_presc   = r_presc;
        n_counter = r_counter;
        w_ovf     = 1'b0;
        if (i_step) begin
            n_presc = w_acc;
            if (w_acc > w_per) begin
                n_presc = w_acc & (w_per - 11'd1);
                if (w_inc == 8'd0) begin
                    w_ovf     = 1'b1;
                    n_counter = i_reload;
                end else begin
                    n_counter = w_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_presc   <= '0;
            r_counter <= '0;
        end else begin
            r_presc   <= n_presc;
            r_counter <= n_counter;
        end
    end

    assign o_stat.ovf     = w_ovf;
    assign o_stat.counter = n_counter;

endmodule

@@ hw/rtl/ict_irq.sv @@
// Pending flags, raise gating and interrupt dispatch at instruction boundaries.
module ict_irq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [1:0]                  i_func,
    input  logic [2:0]                  i_source,
    input  logic                        i_master_enable,
    input  logic                        i_halted,
    input  logic                        i_defer,
    input  logic [15:0]                 i_pc,
    input  logic [15:0]                 i_sp,
    input  logic [ict_pkg::NUM_SRC-1:0] i_mask,
    input  logic                        i_lcd_on,
    input  logic                        i_tmr_ovf,
    output ict_pkg::t_irq_res           o_res
);

    logic [ict_pkg::NUM_SRC-1:0] r_pending;
    logic [ict_pkg::NUM_SRC-1:0] n_pending;
    logic [ict_pkg::NUM_SRC-1:0] w_ready;
    logic [2:0]                  w_sel;
    logic                        w_me;
    logic                        w_halt;
    logic                        w_defer;

    always_comb begin
        n_pending = r_pending;
        w_ready   = r_pending & i_mask;
        w_sel     = '0;
        for (int i = ict_pkg::NUM_SRC - 1; i >= 0; i--) begin
            if (w_ready[i]) begin
                w_sel = 3'(i);
            end
        end
        w_me            = i_master_enable;
        w_halt          = i_halted;
        w_defer         = i_defer;
        o_res.taken      = 1'b0;
        o_res.vector     = '0;
        o_res.push_addr  = '0;
        o_res.push_value = '0;
        o_res.new_sp     = '0;

        case (i_func)
            ict_pkg::FUNC_TICK: begin
                if (i_tmr_ovf) begin
                    n_pending[ict_pkg::SRC_TIMER] = 1'b1;
                end
            end
            ict_pkg::FUNC_RAISE: begin
                if (i_source <= ict_pkg::SRC_PAD &&
                    (i_lcd_on || i_source > ict_pkg::SRC_LCD)) begin
                    n_pending[i_source] = 1'b1;
                end
            end
            ict_pkg::FUNC_BOUNDARY: begin
                w_defer = 1'b0;
                if (!i_defer && w_ready != '0 && (i_master_enable || i_halted)) begin
                    n_pending[w_sel] = 1'b0;
                    o_res.taken      = 1'b1;
                    o_res.vector     = ict_pkg::vector_of(w_sel);
                    o_res.push_value = i_halted ? i_pc + 16'd1 : i_pc;
                    o_res.push_addr  = i_sp - 16'd2;
                    o_res.new_sp     = i_sp - 16'd2;
                    w_me             = 1'b0;
                    w_halt           = 1'b0;
                end
            end
            default: begin
            end
        endcase

        o_res.pending   = n_pending;
        o_res.attention = ((n_pending & i_mask) != '0 && (w_me || w_halt)) || w_defer;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (i_step) begin
            r_pending <= n_pending;
        end
    end

endmodule

@@ hw/rtl/interrupt_controller_with_timer.sv @@
// An input beat reaches the result beat through the input register, then the result register.
// Throughput: one beat per cycle; the input register holds only while a result waits.
// Flags and timer update as an item moves from the input register to the result register.
// Reset (synchronous, active low): both stages empty, flags, prescaler and counter zero,
// configuration at its defaults with the display enabled.
module interrupt_controller_with_timer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ict_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ict_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_func,
    input  logic [5:0]                      i_cycles,
    input  logic [2:0]                      i_source,
    input  logic                            i_master_enable,
    input  logic                            i_halted,
    input  logic                            i_defer,
    input  logic [15:0]                     i_pc,
    input  logic [15:0]                     i_sp,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_taken,
    output logic [6:0]                      o_vector,
    output logic [15:0]                     o_push_addr,
    output logic [15:0]                     o_push_value,
    output logic [15:0]                     o_new_sp,
    output logic [4:0]                      o_pending_flags,
    output logic [7:0]                      o_counter_now,
    output logic                            o_attention
);

    logic [ict_pkg::NUM_SRC-1:0] r_irq_mask;
    logic                        r_timer_on;
    logic [1:0]                  r_timer_rate;
    logic [7:0]                  r_reload;
    logic                        r_lcd_on;

    logic        r_in_valid;
    logic [1:0]  r_func;
    logic [5:0]  r_cycles;
    logic [2:0]  r_source;
    logic        r_me;
    logic        r_halted;
    logic        r_defer;
    logic [15:0] r_pc;
    logic [15:0] r_sp;

    logic              r_out_valid;
    ict_pkg::t_irq_res r_res;
    logic [7:0]        r_counter_now;

    logic               w_adv;
    logic               w_go;
    ict_pkg::t_tmr_stat w_tmr;
    ict_pkg::t_irq_res  w_res;

    assign w_adv      = !r_out_valid || i_out_ready;
    assign w_go       = r_in_valid && w_adv;
    assign o_in_ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irq_mask   <= '0;
            r_timer_on   <= 1'b0;
            r_timer_rate <= '0;
            r_reload     <= '0;
            r_lcd_on     <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ict_pkg::CFG_IRQ_MASK:   r_irq_mask   <= i_cfg_data[ict_pkg::NUM_SRC-1:0];
                ict_pkg::CFG_TIMER_ON:   r_timer_on   <= i_cfg_data[0];
                ict_pkg::CFG_TIMER_RATE: r_timer_rate <= i_cfg_data[1:0];
                ict_pkg::CFG_RELOAD:     r_reload     <= i_cfg_data[7:0];
                ict_pkg::CFG_LCD_ON:     r_lcd_on     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_func   <= i_func;
            r_cycles <= i_cycles;
            r_source <= i_source;
            r_me     <= i_master_enable;
            r_halted <= i_halted;
            r_defer  <= i_defer;
            r_pc     <= i_pc;
            r_sp     <= i_sp;
        end
    end

    ict_timer u_timer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_go && r_func == ict_pkg::FUNC_TICK && r_timer_on),
        .i_cycles (r_cycles),
        .i_rate   (r_timer_rate),
        .i_reload (r_reload),
        .o_stat   (w_tmr)
    );

    ict_irq u_irq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_go),
        .i_func          (r_func),
        .i_source        (r_source),
        .i_master_enable (r_me),
        .i_halted        (r_halted),
        .i_defer         (r_defer),
        .i_pc            (r_pc),
        .i_sp            (r_sp),
        .i_mask          (r_irq_mask),
        .i_lcd_on        (r_lcd_on),
        .i_tmr_ovf       (w_tmr.ovf),
        .o_res           (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_res         <= w_res;
            r_counter_now <= w_tmr.counter;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_taken         = r_res.taken;
    assign o_vector        = r_res.vector;
    assign o_push_addr     = r_res.push_addr;
    assign o_push_value    = r_res.push_value;
    assign o_new_sp        = r_res.new_sp;
    assign o_pending_flags = r_res.pending;
    assign o_counter_now   = r_counter_now;
    assign o_attention     = r_res.attention;

endmodule

@@ hw/rtl/ict_checker.sv @@
// Port-level checks for the interrupt controller with timer, bound to the top level.
module ict_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_taken,
    input logic [6:0]  o_vector,
    input logic [15:0] o_push_addr,
    input logic [15:0] o_push_value,
    input logic [15:0] o_new_sp,
    input logic [4:0]  o_pending_flags,
    input logic [7:0]  o_counter_now,
    input logic        o_attention
);

    a_taken_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_taken |-> o_new_sp == o_push_addr &&
        (o_vector == 7'h40 || o_vector == 7'h48 || o_vector == 7'h50 ||
         o_vector == 7'h58 || o_vector == 7'h60))
        else $error("taken beat with bad vector or stack fields");

    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_taken |-> o_vector == 7'h00 && o_push_addr == 16'h0000 &&
        o_push_value == 16'h0000 && o_new_sp == 16'h0000)
        else $error("dispatch fields nonzero without a taken interrupt");

    a_taken_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_taken |-> !o_attention)
        else $error("attention set on the beat that took an interrupt");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pending_flags) &&
        $stable(o_counter_now))
        else $error("result beat changed while stalled");

endmodule

bind interrupt_controller_with_timer ict_checker u_ict_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_taken         (o_taken),
    .o_vector        (o_vector),
    .o_push_addr     (o_push_addr),
    .o_push_value    (o_push_value),
    .o_new_sp        (o_new_sp),
    .o_pending_flags (o_pending_flags),
    .o_counter_now   (o_counter_now),
    .o_attention     (o_attention)
);

@@ tb/sv/tb_interrupt_controller_with_timer.sv @@
// Self-checking testbench for the interrupt controller with timer: directed table plus random phases.
`timescale 1ns / 100ps

module tb_interrupt_controller_with_timer;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam logic [2:0] SRC_NONE    = 3'd7;
    localparam logic [6:0] VEC_BASE    = 7'h40;
    localparam int         N_PHASES    = 12;
    localparam int         PHASE_ITEMS = 142;
    localparam int         PRESS_AT    = 400;
    localparam int         PRESS_LEN   = 80;

    typedef struct packed {
        logic [1:0]  func;
        logic [5:0]  cycles;
        logic [2:0]  source;
        logic        me;
        logic        halted;
        logic        defer;
        logic [15:0] pc;
        logic [15:0] sp;
    } t_item;

    typedef struct packed {
        logic        taken;
        logic [6:0]  vector;
        logic [15:0] push_addr;
        logic [15:0] push_value;
        logic [15:0] new_sp;
        logic [4:0]  flags;
        logic [7:0]  count;
        logic        attention;
    } t_status;

    typedef struct packed {
        logic                          is_cfg;
        logic [ict_pkg::CFG_IDX_W-1:0] idx;
        logic [7:0]                    data;
        logic                          typed;
        t_item                         it;
        t_status                       want;
    } t_row;

    logic                           i_clk           = 1'b0;
    logic                           i_rst_n         = 1'b0;
    logic                           i_cfg_we        = 1'b0;
    logic [ict_pkg::CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [ict_pkg::CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                           i_in_valid      = 1'b0;
    logic                           o_in_ready;
    logic [1:0]                     i_func          = '0;
    logic [5:0]                     i_cycles        = '0;
    logic [2:0]                     i_source        = '0;
    logic                           i_master_enable = 1'b0;
    logic                           i_halted        = 1'b0;
    logic                           i_defer         = 1'b0;
    logic [15:0]                    i_pc            = '0;
    logic [15:0]                    i_sp            = '0;
    logic                           o_out_valid;
    logic                           i_out_ready     = 1'b0;
    logic                           o_taken;
    logic [6:0]                     o_vector;
    logic [15:0]                    o_push_addr;
    logic [15:0]                    o_push_value;
    logic [15:0]                    o_new_sp;
    logic [4:0]                     o_pending_flags;
    logic [7:0]                     o_counter_now;
    logic                           o_attention;

    // predictor state and configuration
    logic [4:0]  pend_flags;
    logic [10:0] presc;
    logic [7:0]  tmr_count;
    logic [4:0]  en_mask;
    logic        tmr_on;
    logic [1:0]  tmr_rate;
    logic [7:0]  tmr_reload;
    logic        lcd_on;

    t_status     due_status[$];
    t_row        plan[$];
    t_status     head;
    int          fail_cnt   = 0;
    int          beats_seen = 0;
    int          rx_hold    = 0;
    int          rx_calm    = 0;
    int          pick;
    bit          rx_pressed = 1'b0;
    bit          tight      = 1'b0;

    interrupt_controller_with_timer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_func          (i_func),
        .i_cycles        (i_cycles),
        .i_source        (i_source),
        .i_master_enable (i_master_enable),
        .i_halted        (i_halted),
        .i_defer         (i_defer),
        .i_pc            (i_pc),
        .i_sp            (i_sp),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_taken         (o_taken),
        .o_vector        (o_vector),
        .o_push_addr     (o_push_addr),
        .o_push_value    (o_push_value),
        .o_new_sp        (o_new_sp),
        .o_pending_flags (o_pending_flags),
        .o_counter_now   (o_counter_now),
        .o_attention     (o_attention)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic t_status advance_controller(input t_item it);
        t_status     s;
        logic [10:0] per;
        logic [4:0]  rdy;
        int unsigned src;
        logic        me;
        logic        hl;
        logic        df;
        s  = '0;
        me = it.me;
        hl = it.halted;
        df = it.defer;
        case (it.func)
            ict_pkg::FUNC_TICK: begin
                if (tmr_on) begin
                    case (tmr_rate)
                        2'd0:    per = 11'd1024;
                        2'd1:    per = 11'd16;
                        2'd2:    per = 11'd64;
                        default: per = 11'd256;
                    endcase
                    presc = presc + 11'(it.cycles);
                    if (presc > per) begin
                        presc     = presc & (per - 11'd1);
                        tmr_count = tmr_count + 8'd1;
                        if (tmr_count == 8'd0) begin
                            pend_flags[ict_pkg::SRC_TIMER] = 1'b1;
                            tmr_count                      = tmr_reload;
                        end
                    end
                end
            end
            ict_pkg::FUNC_RAISE: begin
                if (it.source <= ict_pkg::SRC_PAD && (lcd_on || it.source > ict_pkg::SRC_LCD))
                    pend_flags[it.source] = 1'b1;
            end
            ict_pkg::FUNC_BOUNDARY: begin
                if (df) begin
                    df = 1'b0;
                end else begin
                    rdy = pend_flags & en_mask;
                    if (rdy != 5'd0 && (me || hl)) begin
                        src = 0;
                        while (!rdy[src])
                            src++;
                        pend_flags[src] = 1'b0;
                        s.taken      = 1'b1;
                        s.vector     = VEC_BASE + 7'(src * 8);
                        s.push_value = hl ? it.pc + 16'd1 : it.pc;
                        s.push_addr  = it.sp - 16'd2;
                        s.new_sp     = s.push_addr;
                        me = 1'b0;
                        hl = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        s.flags     = pend_flags;
        s.count     = tmr_count;
        s.attention = (((pend_flags & en_mask) != 5'd0) && (me || hl)) || df;
        return s;
    endfunction

    function automatic t_item mk(input logic [1:0] func, input logic [5:0] cyc,
                                 input logic [2:0] src, input logic me, input logic hl,
                                 input logic df, input logic [15:0] pc,
                                 input logic [15:0] sp);
        t_item it;
        it = '{func, cyc, src, me, hl, df, pc, sp};
        return it;
    endfunction

    function automatic t_status st(input logic tk, input logic [6:0] vec,
                                   input logic [15:0] pa, input logic [15:0] pv,
                                   input logic [15:0] nsp, input logic [4:0] fl,
                                   input logic [7:0] cnt, input logic att);
        t_status s;
        s = '{tk, vec, pa, pv, nsp, fl, cnt, att};
        return s;
    endfunction

    task automatic add_cfg(input logic [ict_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] data);
        t_row r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        plan.push_back(r);
    endtask

    task automatic add_item(input t_item it);
        t_row r;
        r    = '0;
        r.it = it;
        plan.push_back(r);
    endtask

    task automatic add_typed(input t_item it, input t_status want);
        t_row r;
        r       = '0;
        r.it    = it;
        r.typed = 1'b1;
        r.want  = want;
        plan.push_back(r);
    endtask

    task automatic apply_reg(input logic [ict_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] data);
        case (idx)
            ict_pkg::CFG_IRQ_MASK:   en_mask    = data[4:0];
            ict_pkg::CFG_TIMER_ON:   tmr_on     = data[0];
            ict_pkg::CFG_TIMER_RATE: tmr_rate   = data[1:0];
            ict_pkg::CFG_RELOAD:     tmr_reload = data;
            ict_pkg::CFG_LCD_ON:     lcd_on     = data[0];
            default: ;
        endcase
    endtask

    task automatic write_reg(input logic [ict_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        apply_reg(idx, data);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // drop valid and wait until every result is back
    task automatic settle();
        i_in_valid <= 1'b0;
        while (due_status.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (tight || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 30);
    endfunction

    task automatic send_item(input t_item it, input logic typed, input t_status want);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_func          <= it.func;
        i_cycles        <= it.cycles;
        i_source        <= it.source;
        i_master_enable <= it.me;
        i_halted        <= it.halted;
        i_defer         <= it.defer;
        i_pc            <= it.pc;
        i_sp            <= it.sp;
        i_in_valid      <= 1'b1;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        head = advance_controller(it);
        due_status.push_back(typed ? want : head);
    endtask

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h0001;
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly well-formed traffic, some unused kinds and unknown sources
    function automatic t_item rand_item();
        t_item it;
        int    r;
        it = t_item'({$urandom, $urandom});
        r  = $urandom_range(0, 99);
        if (r < 45) begin
            it.func   = ict_pkg::FUNC_TICK;
            it.cycles = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                    : 6'($urandom_range(4, 24));
        end else if (r < 65) begin
            it.func   = ict_pkg::FUNC_RAISE;
            it.source = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                    : 3'($urandom_range(0, 4));
        end else if (r < 95) begin
            it.func  = ict_pkg::FUNC_BOUNDARY;
            it.defer = ($urandom_range(0, 4) == 0);
            it.pc    = rand_word();
            it.sp    = rand_word();
        end else begin
            it.func = FUNC_UNUSED;
        end
        return it;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            beats_seen++;
            if (due_status.size() == 0) begin
                $error("result beat with nothing expected");
                fail_cnt++;
            end else begin
                head = due_status.pop_front();
                check_field("taken", head.taken, o_taken);
                check_field("vector", head.vector, o_vector);
                check_field("push_addr", head.push_addr, o_push_addr);
                check_field("push_value", head.push_value, o_push_value);
                check_field("new_sp", head.new_sp, o_new_sp);
                check_field("pending_flags", head.flags, o_pending_flags);
                check_field("counter_now", head.count, o_counter_now);
                check_field("attention", head.attention, o_attention);
            end
        end
    end

    // result side: random stalls, calm stretches, one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (!rx_pressed && beats_seen >= PRESS_AT) begin
            rx_pressed  <= 1'b1;
            rx_hold     <= PRESS_LEN;
            i_out_ready <= 1'b0;
        end else if (rx_hold != 0) begin
            rx_hold     <= rx_hold - 1;
            i_out_ready <= 1'b0;
        end else if (rx_calm != 0) begin
            rx_calm     <= rx_calm - 1;
            i_out_ready <= 1'b1;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
                rx_hold <= $urandom_range(6, 30);
            else if (pick < 6)
                rx_calm <= $urandom_range(20, 60);
            i_out_ready <= (pick >= 3 && pick < 6) || pick >= 25;
        end
    end

    initial begin
        logic [7:0] v_mask;
        logic [7:0] v_on;
        logic [7:0] v_rate;
        logic [7:0] v_reload;
        logic [7:0] v_lcd;

        pend_flags = '0;
        presc      = '0;
        tmr_count  = '0;
        en_mask    = '0;
        tmr_on     = 1'b0;
        tmr_rate   = '0;
        tmr_reload = '0;
        lcd_on     = 1'b1;

        // directed table, defaults after reset first
        add_typed(mk(ict_pkg::FUNC_TICK, 6'd48, ict_pkg::SRC_VBLANK, 0, 0, 0,
                     16'h0000, 16'h0000),
                  st(0, 0, 0, 0, 0, 5'h00, 8'h00, 0));
        add_typed(mk(FUNC_UNUSED, 6'd63, SRC_NONE, 1, 1, 1, 16'hFFFF, 16'hFFFF),
                  st(0, 0, 0, 0, 0, 5'h00, 8'h00, 1));
        add_typed(mk(ict_pkg::FUNC_RAISE, 6'd0, SRC_NONE, 0, 0, 0, 16'h0000, 16'h0000),
                  st(0, 0, 0, 0, 0, 5'h00, 8'h00, 0));
        add_typed(mk(ict_pkg::FUNC_RAISE, 6'd0, ict_pkg::SRC_VBLANK, 1, 0, 0,
                     16'h0000, 16'h0000),
                  st(0, 0, 0, 0, 0, 5'h01, 8'h00, 0));
        add_typed(mk(ict_pkg::FUNC_BOUNDARY, 6'd0, ict_pkg::SRC_VBLANK, 1, 0, 0,
                     16'h1234, 16'h0100),
                  st(0, 0, 0, 0, 0, 5'h01, 8'h00, 0));
        add_cfg(ict_pkg::CFG_IRQ_MASK, 8'h1F);
        add_typed(mk(ict_pkg::FUNC_BOUNDARY, 6'd0, ict_pkg::SRC_VBLANK, 1, 0, 1,
                     16'h1234, 16'h0100),
                  st(0, 0, 0, 0, 0, 5'h01, 8'h00, 1));
        add_typed(mk(ict_pkg::FUNC_BOUNDARY, 6'd0, ict_pkg::SRC_VBLANK, 1, 0, 0,
                     16'h1234, 16'h0000),
                  st(1, 7'h40, 16'hFFFE, 16'h1234, 16'hFFFE, 5'h00, 8'h00, 0));
        add_item(mk(ict_pkg::FUNC_RAISE, 6'd0, ict_pkg::SRC_LCD, 0, 0, 0, 16'h0000, 16'h0000));
        add_item(mk(ict_pkg::FUNC_RAISE, 6'd0, ict_pkg::SRC_TIMER, 0, 0, 0, 16'h0000, 16'h0000));
        add_item(mk(ict_pkg::FUNC_RAISE, 6'd0, ict_pkg::SRC_SERIAL, 0, 0, 0,
                    16'h0000, 16'h0000));
        add_item(mk(ict_pkg::FUNC_RAISE, 6'd0, ict_pkg::SRC_PAD, 0, 0, 0, 16'h0000, 16'h0000));
        add_typed(mk(ict_pkg::FUNC_BOUNDARY, 6'd0, ict_pkg::SRC_VBLANK, 0, 1, 0,
                     16'hFFFF, 16'h0001),
                  st(1, 7'h48, 16'hFFFF, 16'h0000, 16'hFFFF, 5'h1C, 8'h00, 0));
        add_cfg(ict_pkg::CFG_LCD_ON, 8'h00);
        add_item(mk(ict_pkg::FUNC_RAISE, 6'd0, ict_pkg::SRC_VBLANK, 0, 0, 0,
                    16'h0000, 16'h0000));
        add_item(mk(ict_pkg::FUNC_RAISE, 6'd0, ict_pkg::SRC_LCD, 0, 0, 0, 16'h0000, 16'h0000));
        add_item(mk(ict_pkg::FUNC_BOUNDARY, 6'd0, ict_pkg::SRC_VBLANK, 0, 0, 0,
                    16'h4000, 16'hC000));
        add_cfg(ict_pkg::CFG_TIMER_ON, 8'h01);
        add_cfg(ict_pkg::CFG_TIMER_RATE, 8'h01);
        add_cfg(ict_pkg::CFG_RELOAD, 8'hFF);
        add_item(mk(ict_pkg::FUNC_TICK, 6'd16, ict_pkg::SRC_VBLANK, 0, 0, 0, 16'h0000, 16'h0000));
        add_item(mk(ict_pkg::FUNC_TICK, 6'd1, ict_pkg::SRC_VBLANK, 0, 0, 0, 16'h0000, 16'h0000));
        add_item(mk(ict_pkg::FUNC_TICK, 6'd48, ict_pkg::SRC_VBLANK, 0, 0, 0, 16'h0000, 16'h0000));
        add_item(mk(ict_pkg::FUNC_TICK, 6'd0, ict_pkg::SRC_VBLANK, 0, 0, 0, 16'h0000, 16'h0000));
        add_cfg(ict_pkg::CFG_TIMER_ON, 8'h00);
        add_item(mk(ict_pkg::FUNC_TICK, 6'd48, ict_pkg::SRC_VBLANK, 0, 0, 0, 16'h0000, 16'h0000));
        add_item(mk(ict_pkg::FUNC_BOUNDARY, 6'd0, ict_pkg::SRC_VBLANK, 1, 1, 0,
                    16'h8000, 16'h0002));
        add_item(mk(ict_pkg::FUNC_BOUNDARY, 6'd0, ict_pkg::SRC_VBLANK, 1, 0, 0,
                    16'h5555, 16'hAAAA));
        add_item(mk(ict_pkg::FUNC_BOUNDARY, 6'd0, ict_pkg::SRC_VBLANK, 1, 0, 0,
                    16'hAAAA, 16'h5555));
        add_item(mk(ict_pkg::FUNC_BOUNDARY, 6'd0, ict_pkg::SRC_VBLANK, 1, 1, 0,
                    16'h0001, 16'hFFFF));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < plan.size(); i++) begin
            if (plan[i].is_cfg) begin
                settle();
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                send_item(plan[i].it, plan[i].typed, plan[i].want);
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            v_mask   = (p == 0) ? 8'h00 : (p % 3 == 1) ? 8'h1F : 8'($urandom_range(0, 31));
            v_on     = (p % 6 == 5) ? 8'h00 : 8'h01;
            v_rate   = 8'(p % 4);
            v_reload = (p == 2) ? 8'h00 : (p % 3 == 0) ? 8'hFF
                                        : 8'($urandom_range(200, 255));
            v_lcd    = (p % 4 == 1) ? 8'h00 : 8'h01;
            tight    = (p % 4 == 3);
            settle();
            write_reg(ict_pkg::CFG_IRQ_MASK, v_mask);
            write_reg(ict_pkg::CFG_TIMER_ON, v_on);
            write_reg(ict_pkg::CFG_TIMER_RATE, v_rate);
            write_reg(ict_pkg::CFG_RELOAD, v_reload);
            write_reg(ict_pkg::CFG_LCD_ON, v_lcd);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(rand_item(), 1'b0, '0);
        end

        settle();
        repeat (10) @(posedge i_clk);
        if (due_status.size() != 0) begin
            $error("%0d results never arrived", due_status.size());
            fail_cnt++;
        end
        if (fail_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/ict_pkg.sv
hw/rtl/ict_timer.sv
hw/rtl/ict_irq.sv
hw/rtl/interrupt_controller_with_timer.sv
hw/rtl/ict_checker.sv
tb/sv/tb_interrupt_controller_with_timer.sv
